// ----- rtl/core/jetp_pkg.sv -----
// Package for the Julia escape-time pixel unit.
// Holds the number format, register indexes and the command and status types.
// No dependencies.
package jetp_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 28;
	localparam int WORD_BITS  = FRAC_BITS + 4;
	localparam int PROD_BITS  = 2 * WORD_BITS;
	localparam int ITER_LIMIT = 1000;
	localparam int CNT_W      = 10;
	localparam int Q_W        = 16;
	localparam int DIV_W      = CNT_W + Q_W;
	localparam int CFG_AW     = 3;
	localparam int CFG_DW     = 32;

	localparam logic [CFG_AW-1:0] REG_C_REAL    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_C_IMAG    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_MAX_ITER  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_RE_ORIGIN = 3'd3;
	localparam logic [CFG_AW-1:0] REG_RE_STEP   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_IM_ORIGIN = 3'd5;
	localparam logic [CFG_AW-1:0] REG_IM_STEP   = 3'd6;

	typedef struct packed {
		logic       load_xy;
		logic       init_z;
		logic       do_mul;
		logic       do_upd;
		logic       cnt_inc;
		logic       div_start;
		logic       div_step;
		logic       col_en;
		logic [1:0] col_sel;
		logic       out_load;
	} jetp_cmd_t;

	typedef struct packed {
		logic lim_zero;
		logic escaped;
		logic last_iter;
	} jetp_sts_t;

endpackage

// ----- rtl/core/julia_escape_time_pixel_unit.sv -----
// Julia escape-time pixel unit, top level: controller plus datapath.
// An input transfer is followed by load, start of z and a loop of multiply and update
// states, one pass more than the counted iterations; when the point escapes a final
// test, division and colour follow before the output transfer.
// One pixel at a time; a new pixel is accepted only while the unit is idle.
// Reset is asynchronous and active low; it restores the register defaults.
module julia_escape_time_pixel_unit import jetp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_AW-1:0]     cfg_addr,
	input  logic [CFG_DW-1:0]     cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CNT_W-1:0]      iter_count,
	output logic                  inside_set,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue
);

	jetp_cmd_t cmd;
	jetp_sts_t sts;

	jetp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	jetp_dp u_dp (
		.clk, .arst_n, .cfg_we, .cfg_addr, .cfg_wdata, .pixel_x, .pixel_y,
		.cmd, .sts, .iter_count, .inside_set, .red, .green, .blue
	);

	// A result that lies inside the set is black.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_set |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("inside pixel not black");

	// In the cycle after an input transfer the unit is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> iter_count <= CNT_W'(ITER_LIMIT))
		else $error("iteration count above limit");

endmodule

// ----- rtl/core/jetp_dp.sv -----
// Datapath of the Julia escape-time pixel unit: registers, iteration,
// divider and colour polynomials. Depends on jetp_pkg.
module jetp_dp import jetp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_AW-1:0]     cfg_addr,
	input  logic [CFG_DW-1:0]     cfg_wdata,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  jetp_cmd_t             cmd,
	output jetp_sts_t             sts,
	output logic [CNT_W-1:0]      iter_count,
	output logic                  inside_set,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue
);

	logic [30:0] c_real_q, c_imag_q, re_step_q, im_step_q;
	logic [31:0] re_origin_q, im_origin_q;
	logic [CNT_W-1:0] max_iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q    <= 31'h74CCCCCD;
			c_imag_q    <= 31'd72521549;
			max_iter_q  <= 10'd100;
			re_origin_q <= 32'hE0000000;
			re_step_q   <= 31'd1344158;
			im_origin_q <= 32'h20000000;
			im_step_q   <= 31'd1795534;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_C_REAL:    c_real_q    <= cfg_wdata[30:0];
				REG_C_IMAG:    c_imag_q    <= cfg_wdata[30:0];
				REG_MAX_ITER:  max_iter_q  <= cfg_wdata[CNT_W-1:0];
				REG_RE_ORIGIN: re_origin_q <= cfg_wdata;
				REG_RE_STEP:   re_step_q   <= cfg_wdata[30:0];
				REG_IM_ORIGIN: im_origin_q <= cfg_wdata;
				REG_IM_STEP:   im_step_q   <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	logic [COORD_BITS-1:0] x_q, y_q;
	logic [CNT_W-1:0] lim_q, cnt_q;
	logic signed [WORD_BITS-1:0] zr_q, zi_q;
	logic signed [PROD_BITS-1:0] prr_q, pii_q, pri_q;
	logic [CNT_W+COORD_BITS+20:0] xm, ym;
	logic [WORD_BITS-1:0] cr, ci, nr, ni;
	logic [PROD_BITS-1:0] mag2;

	assign xm = {{(CNT_W+COORD_BITS+21-COORD_BITS){1'b0}}, x_q} * {{(CNT_W+COORD_BITS-10){1'b0}}, re_step_q};
	assign ym = {{(CNT_W+COORD_BITS+21-COORD_BITS){1'b0}}, y_q} * {{(CNT_W+COORD_BITS-10){1'b0}}, im_step_q};
	assign cr = {c_real_q[30], c_real_q};
	assign ci = {c_imag_q[30], c_imag_q};
	assign nr = prr_q[FRAC_BITS+WORD_BITS-1:FRAC_BITS] - pii_q[FRAC_BITS+WORD_BITS-1:FRAC_BITS] + cr;
	assign ni = pri_q[FRAC_BITS+WORD_BITS-2:FRAC_BITS-1] + ci;
	assign mag2 = prr_q + pii_q;

	assign sts.lim_zero  = (lim_q == '0);
	assign sts.escaped   = (mag2 > (64'd1 << (2 * FRAC_BITS + 2)));
	assign sts.last_iter = ((cnt_q + 1'b1) == lim_q);

	always_ff @(posedge clk) begin
		if (cmd.load_xy) begin
			x_q   <= pixel_x;
			y_q   <= pixel_y;
			lim_q <= (max_iter_q > CNT_W'(ITER_LIMIT)) ? CNT_W'(ITER_LIMIT) : max_iter_q;
		end
		if (cmd.init_z) begin
			zr_q  <= re_origin_q + xm[WORD_BITS-1:0];
			zi_q  <= im_origin_q - ym[WORD_BITS-1:0];
			cnt_q <= '0;
		end
		if (cmd.do_mul) begin
			prr_q <= zr_q * zr_q;
			pii_q <= zi_q * zi_q;
			pri_q <= zr_q * zi_q;
		end
		if (cmd.do_upd) begin
			zr_q <= nr;
			zi_q <= ni;
		end
		if (cmd.cnt_inc)
			cnt_q <= cnt_q + 1'b1;
	end

	// Restoring divider for t = (count << 16) / limit, one quotient bit a cycle.
	logic [DIV_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [Q_W-1:0] quo_q;
	logic [CNT_W:0] trial;
	logic qbit;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign qbit  = (trial >= {1'b0, lim_q});

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= {cnt_q, {Q_W{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q <= qbit ? CNT_W'(trial - {1'b0, lim_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], qbit};
		end
	end

	// Three polynomial lanes, one multiplication each per step.
	logic [Q_W:0] t, u, ar_q, ag_q, ab_q, mr_a, mg_a, mb_a, mr_b, mg_b, mb_b;
	logic [2*Q_W+1:0] mr, mg, mb;
	logic [7:0] r_q, g_q, b_q;
	logic [29:0] fr, fg, fb;

	assign t = {1'b0, quo_q};
	assign u = (17'd1 << Q_W) - t;

	always_comb begin
		mr_a = ar_q; mg_a = ag_q; mb_a = ab_q;
		mr_b = t;    mg_b = t;    mb_b = t;
		case (cmd.col_sel)
			2'd0: begin
				mr_a = u; mg_a = u; mb_a = u;
				mg_b = u; mb_b = u;
			end
			2'd1: mb_b = u;
			default: ;
		endcase
	end

	assign mr = mr_a * mr_b;
	assign mg = mg_a * mg_b;
	assign mb = mb_a * mb_b;
	assign fr = 30'd2295 * {13'd0, ar_q};
	assign fg = 30'd3825 * {13'd0, ag_q};
	assign fb = 30'd4335 * {13'd0, ab_q};

	always_ff @(posedge clk) begin
		if (cmd.col_en) begin
			if (cmd.col_sel == 2'd3) begin
				r_q <= (fr[29:16] > 14'd255) ? 8'hFF : fr[23:16];
				g_q <= (fg[29:16] > 14'd255) ? 8'hFF : fg[23:16];
				b_q <= (fb[29:17] > 13'd255) ? 8'hFF : fb[24:17];
			end else begin
				ar_q <= mr[2*Q_W:Q_W];
				ag_q <= mg[2*Q_W:Q_W];
				ab_q <= mb[2*Q_W:Q_W];
			end
		end
	end

	logic ins;
	assign ins = (cnt_q == lim_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			iter_count <= cnt_q;
			inside_set <= ins;
			red        <= ins ? 8'd0 : r_q;
			green      <= ins ? 8'd0 : g_q;
			blue       <= ins ? 8'd0 : b_q;
		end
	end

endmodule

// ----- rtl/core/jetp_ctrl.sv -----
// Controller of the Julia escape-time pixel unit: sequences load, iteration,
// division, colour and output transfer. Depends on jetp_pkg.
module jetp_ctrl import jetp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  jetp_sts_t sts,
	output jetp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_COL  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q, state_d;
	logic first_q, first_d, ov_q, ov_d;
	logic [4:0] div_q, div_d;
	logic [1:0] col_q, col_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		state_d  = state_q;
		first_d  = first_q;
		div_d    = div_q;
		col_d    = col_q;
		ov_d     = ov_q && !out_ready;
		cmd      = '0;
		cmd.col_sel = col_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.load_xy = 1'b1;
				state_d     = S_LOAD;
			end
			S_LOAD: begin
				cmd.init_z = 1'b1;
				first_d    = 1'b1;
				state_d    = sts.lim_zero ? S_FIN : S_MUL;
			end
			S_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = S_UPD;
			end
			S_UPD: begin
				first_d = 1'b0;
				if (first_q) begin
					cmd.do_upd = 1'b1;
					state_d    = S_MUL;
				end else if (sts.escaped) begin
					cmd.div_start = 1'b1;
					div_d         = '0;
					state_d       = S_DIV;
				end else begin
					cmd.cnt_inc = 1'b1;
					if (sts.last_iter) begin
						state_d  = S_FIN;
					end else begin
						cmd.do_upd = 1'b1;
						state_d    = S_MUL;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				div_d        = div_q + 1'b1;
				if (div_q == 5'(DIV_W - 1)) begin
					col_d   = '0;
					state_d = S_COL;
				end
			end
			S_COL: begin
				cmd.col_en = 1'b1;
				col_d      = col_q + 1'b1;
				if (col_q == 2'd3)
					state_d = S_FIN;
			end
			S_FIN: if (!ov_q || out_ready) begin
				cmd.out_load = 1'b1;
				ov_d         = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			first_q  <= 1'b0;
			ov_q     <= 1'b0;
			div_q    <= '0;
			col_q    <= '0;
		end else begin
			state_q  <= state_d;
			first_q  <= first_d;
			ov_q     <= ov_d;
			div_q    <= div_d;
			col_q    <= col_d;
		end
	end

endmodule

// ----- tb/sv/julia_escape_time_pixel_unit_tb.sv -----
// Self-checking testbench for the Julia escape-time pixel unit.
// Pixels are checked field by field against a fixed-point predictor kept in the bench,
// or against the expected value in the directed table. Depends on jetp_pkg and julia_escape_time_pixel_unit.
`timescale 1ns / 100ps

module julia_escape_time_pixel_unit_tb;
	import jetp_pkg::*;

	localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             ins;
		logic [7:0]       r;
		logic [7:0]       g;
		logic [7:0]       b;
	} pixel_res_t;

	typedef struct {
		int         lim;
		logic [11:0] x;
		logic [11:0] y;
		bit         known;
		pixel_res_t want;
	} pixel_row_t;

	logic clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready, inside_set;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;
	logic [COORD_BITS-1:0] pixel_x, pixel_y;
	logic [CNT_W-1:0] iter_count;
	logic [7:0] red, green, blue;

	// Register copy held by the predictor.
	logic [30:0] cfg_c_re, cfg_c_im, cfg_re_stp, cfg_im_stp;
	logic [9:0]  cfg_lim;
	logic [31:0] cfg_re_org, cfg_im_org;

	pixel_res_t pending_pixels[$];
	int err_count = 0;
	int cycles = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit idle_en = 1;

	julia_escape_time_pixel_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .out_valid(out_valid),
		.out_ready(out_ready), .iter_count(iter_count), .inside_set(inside_set),
		.red(red), .green(green), .blue(blue)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic pixel_res_t colour_pixel(input logic [11:0] x, input logic [11:0] y);
		logic signed [31:0] zr, zi, cr, ci, nr, ni;
		logic signed [63:0] pa, pb, pc;
		logic [63:0] prod, t, u, pr, pg, pbl, r, g, b;
		logic [64:0] mag2;
		int unsigned lim, cnt;
		pixel_res_t res;
		cr = {cfg_c_re[30], cfg_c_re};
		ci = {cfg_c_im[30], cfg_c_im};
		prod = 64'(x) * 64'(cfg_re_stp);
		zr = cfg_re_org + prod[31:0];
		prod = 64'(y) * 64'(cfg_im_stp);
		zi = cfg_im_org - prod[31:0];
		lim = (cfg_lim > ITER_LIMIT) ? ITER_LIMIT : cfg_lim;
		cnt = 0;
		while (cnt < lim) begin
			pa = zr * zr;
			pb = zi * zi;
			pc = zr * zi;
			nr = 32'(pa >>> FRAC_BITS) - 32'(pb >>> FRAC_BITS) + cr;
			ni = 32'(pc >>> (FRAC_BITS - 1)) + ci;
			zr = nr;
			zi = ni;
			pa = zr * zr;
			pb = zi * zi;
			mag2 = {1'b0, pa} + {1'b0, pb};
			if (mag2 > (65'd1 << (2 * FRAC_BITS + 2)))
				break;
			cnt++;
		end
		res = '0;
		res.cnt = cnt[CNT_W-1:0];
		res.ins = (cnt == lim);
		if (!res.ins) begin
			t = (64'(cnt) << 16) / lim;
			u = 64'd65536 - t;
			pr = ((((u * t) >> 16) * t) >> 16) * t >> 16;
			pg = ((((u * u) >> 16) * t) >> 16) * t >> 16;
			pbl = ((((u * u) >> 16) * u) >> 16) * t >> 16;
			r = (64'd2295 * pr) >> 16;
			g = (64'd3825 * pg) >> 16;
			b = (64'd4335 * pbl) >> 17;
			res.r = (r > 255) ? 8'd255 : r[7:0];
			res.g = (g > 255) ? 8'd255 : g[7:0];
			res.b = (b > 255) ? 8'd255 : b[7:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin
		pixel_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected pixel transfer", 1, 0);
			end else begin
				want = pending_pixels.pop_front();
				if (iter_count !== want.cnt) report_mismatch("iter_count", iter_count, want.cnt);
				if (inside_set !== want.ins) report_mismatch("inside_set", inside_set, want.ins);
				if (red !== want.r) report_mismatch("red", red, want.r);
				if (green !== want.g) report_mismatch("green", green, want.g);
				if (blue !== want.b) report_mismatch("blue", blue, want.b);
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			out_ready = 1'b0;
			stall_left = $urandom_range(0, 11);
		end else begin
			out_ready = 1'b1;
		end
	end

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = data;
		case (idx)
			REG_C_REAL:    cfg_c_re = data[30:0];
			REG_C_IMAG:    cfg_c_im = data[30:0];
			REG_MAX_ITER:  cfg_lim = data[9:0];
			REG_RE_ORIGIN: cfg_re_org = data;
			REG_RE_STEP:   cfg_re_stp = data[30:0];
			REG_IM_ORIGIN: cfg_im_org = data;
			REG_IM_STEP:   cfg_im_stp = data[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Sender pauses until every outstanding pixel has come back.
	task automatic drain;
		wait (pending_pixels.size() == 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input bit known,
			input pixel_res_t want);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid = 1'b1;
		pixel_x = x;
		pixel_y = y;
		do @(posedge clk); while (!in_ready);
		pending_pixels.push_back(known ? want : colour_pixel(x, y));
	endtask

	pixel_row_t directed[16] = '{
		'{-1, 12'd0, 12'd0, 1, '{10'd0, 1'b0, 8'd0, 8'd0, 8'd0}},
		'{-1, 12'd4095, 12'd4095, 0, '0},
		'{-1, 12'd4095, 12'd0, 0, '0},
		'{-1, 12'd0, 12'd4095, 0, '0},
		'{-1, 12'd2048, 12'd1024, 0, '0},
		'{-1, 12'd1365, 12'd2730, 0, '0},
		'{-1, 12'd170, 12'd3925, 0, '0},
		'{-1, 12'd372, 12'd298, 0, '0},
		'{0, 12'd100, 12'd200, 1, '{10'd0, 1'b1, 8'd0, 8'd0, 8'd0}},
		'{0, 12'd4095, 12'd4095, 1, '{10'd0, 1'b1, 8'd0, 8'd0, 8'd0}},
		'{1, 12'd0, 12'd0, 1, '{10'd0, 1'b0, 8'd0, 8'd0, 8'd0}},
		'{1, 12'd2000, 12'd1500, 0, '0},
		'{1000, 12'd372, 12'd298, 0, '0},
		'{1000, 12'd0, 12'd0, 1, '{10'd0, 1'b0, 8'd0, 8'd0, 8'd0}},
		'{1023, 12'd380, 12'd300, 0, '0},
		'{1023, 12'd2100, 12'd2048, 0, '0}
	};

	initial begin
		logic [31:0] lim_w;
		cfg_we = 1'b0;
		cfg_addr = REG_C_REAL;
		cfg_wdata = '0;
		in_valid = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		out_ready = 1'b0;
		cfg_c_re = 31'(-187904819);
		cfg_c_im = 31'd72521549;
		cfg_lim = 10'd100;
		cfg_re_org = 32'(-536870912);
		cfg_re_stp = 31'd1344158;
		cfg_im_org = 32'd536870912;
		cfg_im_stp = 31'd1795534;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			if (directed[i].lim >= 0 && directed[i].lim != cfg_lim) begin
				@(negedge clk);
				in_valid = 1'b0;
				drain();
				write_reg(REG_MAX_ITER, 32'(directed[i].lim));
			end
			send_pixel(directed[i].x, directed[i].y, directed[i].known, directed[i].want);
		end

		for (int ph = 0; ph < 6; ph++) begin
			@(negedge clk);
			in_valid = 1'b0;
			drain();
			case (ph)
				0, 1, 5: begin
					// A window of -2..2 on both axes, where much of the set lies.
					write_reg(REG_C_REAL, 32'($urandom_range(0, 429496729)) - 32'd214748364);
					write_reg(REG_C_IMAG, 32'($urandom_range(0, 429496729)) - 32'd214748364);
					lim_w = (ph == 0) ? 32'd100 : (ph == 1) ? 32'd1000 : 32'd255;
					write_reg(REG_MAX_ITER, lim_w);
					write_reg(REG_RE_ORIGIN, 32'(-536870912));
					write_reg(REG_RE_STEP, 32'd262144);
					write_reg(REG_IM_ORIGIN, 32'd536870912);
					write_reg(REG_IM_STEP, 32'd262144);
				end
				2: begin
					write_reg(REG_C_REAL, 32'(-1073741824));
					write_reg(REG_C_IMAG, 32'd1073741823);
					write_reg(REG_MAX_ITER, 32'd1023);
					write_reg(REG_RE_ORIGIN, 32'h8000_0000);
					write_reg(REG_RE_STEP, 32'h7FFF_FFFF);
					write_reg(REG_IM_ORIGIN, 32'h7FFF_FFFF);
					write_reg(REG_IM_STEP, 32'd0);
					write_reg(REG_UNUSED, $urandom);
				end
				3: begin
					write_reg(REG_MAX_ITER, 32'd0);
					write_reg(REG_RE_STEP, 32'd0);
					write_reg(REG_IM_STEP, 32'h7FFF_FFFF);
				end
				default: begin
					// Full-width random data; bits above each register's width are dropped.
					write_reg(REG_C_REAL, $urandom);
					write_reg(REG_C_IMAG, $urandom);
					write_reg(REG_MAX_ITER, {22'($urandom_range(0, 4194303)),
						10'($urandom_range(1, 1000))});
					write_reg(REG_RE_ORIGIN, $urandom);
					write_reg(REG_RE_STEP, $urandom);
					write_reg(REG_IM_ORIGIN, $urandom);
					write_reg(REG_IM_STEP, $urandom);
				end
			endcase
			if (ph == 1)
				hold_left = 600;
			if (ph == 5)
				idle_en = 0;
			for (int n = 0; n < 100; n++)
				send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 0, '0);
		end

		@(negedge clk);
		in_valid = 1'b0;
		wait (pending_pixels.size() == 0);
		repeat (100) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
